// ===== design/tgq_pkg.sv =====
package tgq_pkg;

    localparam int DATA_W = 31;

    typedef struct packed {
        logic [DATA_W-1:0] first_value;
        logic [DATA_W-1:0] second_value;
    } t_query;

    typedef struct packed {
        logic [DATA_W-1:0] gcd_value;
        logic              out_of_range;
    } t_result;

endpackage

// ===== design/tgq_ram.sv =====
module tgq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/tgq_build.sv =====
module tgq_build #(
    parameter int MAX_N = 4095,
    parameter int ROOT_N = 63,
    localparam int FW = $clog2(MAX_N + 1),
    localparam int GW = $clog2(ROOT_N + 1)
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    output logic            o_ready,
    output logic            o_fac_we,
    output logic [FW-1:0]   o_fac_waddr,
    output logic [3*FW-1:0] o_fac_wdata,
    output logic [FW-1:0]   o_fac_raddr,
    input  logic [3*FW-1:0] i_fac_rdata,
    output logic            o_gcd_we,
    output logic [2*GW-1:0] o_gcd_waddr,
    output logic [3*GW-1:0] o_gcd_wdata
);

    typedef enum logic [8:0] {
        S_CLR  = 9'b000000001,
        S_PRD  = 9'b000000010,
        S_PCHK = 9'b000000100,
        S_MRD  = 9'b000001000,
        S_MCHK = 9'b000010000,
        S_FL   = 9'b000100000,
        S_FF   = 9'b001000000,
        S_FW   = 9'b010000000,
        S_DONE = 9'b100000000
    } t_sieve_state;

    typedef enum logic [4:0] {
        G_LD   = 5'b00001,
        G_EUC  = 5'b00010,
        G_QUO  = 5'b00100,
        G_WR   = 5'b01000,
        G_DONE = 5'b10000
    } t_gcd_state;

    localparam logic [FW:0]   LAST  = (FW + 1)'(MAX_N);
    localparam logic [GW-1:0] GLAST = GW'(ROOT_N);
    localparam logic [3*FW-1:0] ONES = {3{FW'(1)}};

    t_sieve_state r_state, n_state;
    logic [FW-1:0] r_i, n_i, r_m, n_m, r_k, n_k, r_q, n_q;

    logic            lpf_we;
    logic [FW-1:0]   lpf_waddr, lpf_raddr;
    logic [2*FW-1:0] lpf_wdata, lpf_rdata;
    logic [FW-1:0]   lpf_p, lpf_k;
    logic [2*FW-1:0] sq, xq;
    logic [FW:0]     m_next;
    logic            i_last;
    logic [FW-1:0]   fx, fy, fz, a1, b1, sy, sz;

    t_gcd_state r_gstate, n_gstate;
    logic [GW-1:0] r_gi, n_gi, r_gj, n_gj, r_ga, n_ga, r_gb, n_gb, r_gd, n_gd;
    logic [GW-1:0] r_gx, n_gx, r_gy, n_gy, r_gcp, n_gcp, r_gcr, n_gcr;
    logic          gx_ge, gy_ge;
    logic          r_ready;

    tgq_ram #(.WIDTH(2 * FW), .DEPTH(MAX_N + 1)) u_lpf (
        .i_clk   (i_clk),
        .i_we    (lpf_we),
        .i_waddr (lpf_waddr),
        .i_wdata (lpf_wdata),
        .i_raddr (lpf_raddr),
        .o_rdata (lpf_rdata)
    );

    assign lpf_p  = lpf_rdata[2*FW-1:FW];
    assign lpf_k  = lpf_rdata[FW-1:0];
    assign sq     = {{FW{1'b0}}, r_i} * {{FW{1'b0}}, r_i};
    assign m_next = {1'b0, r_m} + {1'b0, r_i};
    assign i_last = ({1'b0, r_i} == LAST);

    assign fx = xq[FW-1:0];
    assign fy = i_fac_rdata[2*FW-1:FW];
    assign fz = i_fac_rdata[3*FW-1:2*FW];
    assign xq = {{FW{1'b0}}, i_fac_rdata[FW-1:0]} * {{FW{1'b0}}, r_q};
    assign a1 = (fx > fy) ? fy : fx;
    assign b1 = (fx > fy) ? fx : fy;
    assign sy = (b1 > fz) ? fz : b1;
    assign sz = (b1 > fz) ? b1 : fz;

    always_comb begin
        n_state     = r_state;
        n_i         = r_i;
        n_m         = r_m;
        n_k         = r_k;
        n_q         = r_q;
        lpf_we      = 1'b0;
        lpf_waddr   = r_i;
        lpf_wdata   = '0;
        lpf_raddr   = r_i;
        o_fac_we    = 1'b0;
        o_fac_waddr = r_i;
        o_fac_wdata = ONES;
        o_fac_raddr = r_i;
        case (r_state)
            S_CLR: begin
                lpf_we   = 1'b1;
                o_fac_we = 1'b1;
                if (i_last) begin
                    n_i = FW'(2);
                    if (MAX_N >= 2) begin
                        n_state = S_PRD;
                    end else begin
                        n_state = S_DONE;
                    end
                end else begin
                    n_i = r_i + FW'(1);
                end
            end
            S_PRD: begin
                n_state = S_PCHK;
            end
            S_PCHK: begin
                if (lpf_p == '0) begin
                    lpf_we    = 1'b1;
                    lpf_wdata = {r_i, FW'(1)};
                end
                if (lpf_p == '0 && sq <= (2 * FW)'(MAX_N)) begin
                    n_m     = sq[FW-1:0];
                    n_k     = r_i;
                    n_state = S_MRD;
                end else if (i_last) begin
                    n_i     = FW'(2);
                    n_state = S_FL;
                end else begin
                    n_i     = r_i + FW'(1);
                    n_state = S_PRD;
                end
            end
            S_MRD: begin
                lpf_raddr = r_m;
                n_state   = S_MCHK;
            end
            S_MCHK: begin
                if (lpf_p == '0) begin
                    lpf_we    = 1'b1;
                    lpf_waddr = r_m;
                    lpf_wdata = {r_i, r_k};
                end
                n_k = r_k + FW'(1);
                if (m_next > LAST) begin
                    if (i_last) begin
                        n_i     = FW'(2);
                        n_state = S_FL;
                    end else begin
                        n_i     = r_i + FW'(1);
                        n_state = S_PRD;
                    end
                end else begin
                    n_m     = m_next[FW-1:0];
                    n_state = S_MRD;
                end
            end
            S_FL: begin
                n_state = S_FF;
            end
            S_FF: begin
                n_q         = lpf_p;
                o_fac_raddr = lpf_k;
                n_state     = S_FW;
            end
            S_FW: begin
                o_fac_we    = 1'b1;
                o_fac_wdata = {sz, sy, a1};
                if (i_last) begin
                    n_state = S_DONE;
                end else begin
                    n_i     = r_i + FW'(1);
                    n_state = S_FL;
                end
            end
            S_DONE: begin
                n_state = S_DONE;
            end
            default: begin
                n_state = S_CLR;
            end
        endcase
    end

    assign gx_ge = (r_gx >= r_gd);
    assign gy_ge = (r_gy >= r_gd);

    always_comb begin
        n_gstate    = r_gstate;
        n_gi        = r_gi;
        n_gj        = r_gj;
        n_ga        = r_ga;
        n_gb        = r_gb;
        n_gd        = r_gd;
        n_gx        = r_gx;
        n_gy        = r_gy;
        n_gcp       = r_gcp;
        n_gcr       = r_gcr;
        o_gcd_we    = 1'b0;
        o_gcd_waddr = {r_gi, r_gj};
        o_gcd_wdata = {r_gd, r_gcp, r_gcr};
        case (r_gstate)
            G_LD: begin
                n_ga     = r_gi;
                n_gb     = r_gj;
                n_gstate = G_EUC;
            end
            G_EUC: begin
                if (r_gb == '0) begin
                    n_gd     = r_ga;
                    n_gx     = r_gi;
                    n_gy     = r_gj;
                    n_gcp    = '0;
                    n_gcr    = '0;
                    n_gstate = G_QUO;
                end else if (r_ga >= r_gb) begin
                    n_ga = r_ga - r_gb;
                end else begin
                    n_ga = r_gb;
                    n_gb = r_ga;
                end
            end
            G_QUO: begin
                if (r_gd == '0 || (!gx_ge && !gy_ge)) begin
                    n_gstate = G_WR;
                end else begin
                    if (gx_ge) begin
                        n_gx  = r_gx - r_gd;
                        n_gcp = r_gcp + GW'(1);
                    end
                    if (gy_ge) begin
                        n_gy  = r_gy - r_gd;
                        n_gcr = r_gcr + GW'(1);
                    end
                end
            end
            G_WR: begin
                o_gcd_we = 1'b1;
                n_gstate = G_LD;
                if (r_gj == GLAST) begin
                    n_gj = '0;
                    if (r_gi == GLAST) begin
                        n_gstate = G_DONE;
                    end else begin
                        n_gi = r_gi + GW'(1);
                    end
                end else begin
                    n_gj = r_gj + GW'(1);
                end
            end
            G_DONE: begin
                n_gstate = G_DONE;
            end
            default: begin
                n_gstate = G_LD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_i      <= '0;
            r_gstate <= G_LD;
            r_gi     <= '0;
            r_gj     <= '0;
            r_ready  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_i      <= n_i;
            r_gstate <= n_gstate;
            r_gi     <= n_gi;
            r_gj     <= n_gj;
            r_ready  <= (r_state == S_DONE) && (r_gstate == G_DONE);
        end
    end

    always_ff @(posedge i_clk) begin
        r_m   <= n_m;
        r_k   <= n_k;
        r_q   <= n_q;
        r_ga  <= n_ga;
        r_gb  <= n_gb;
        r_gd  <= n_gd;
        r_gx  <= n_gx;
        r_gy  <= n_gy;
        r_gcp <= n_gcp;
        r_gcr <= n_gcr;
    end

    assign o_ready = r_ready;

endmodule

// ===== design/tgq_step.sv =====
module tgq_step import tgq_pkg::*; #(
    parameter int MAX_N = 4095,
    parameter int ROOT_N = 63,
    parameter int SW = 8,
    localparam int FW = $clog2(MAX_N + 1),
    localparam int GW = $clog2(ROOT_N + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_gcd_we,
    input  logic [2*GW-1:0]   i_gcd_waddr,
    input  logic [3*GW-1:0]   i_gcd_wdata,
    input  logic              i_valid,
    input  logic [DATA_W-1:0] i_b,
    input  logic [FW-1:0]     i_p,
    input  logic [FW-1:0]     i_ans,
    input  logic [SW-1:0]     i_side,
    output logic              o_valid,
    output logic [DATA_W-1:0] o_b,
    output logic [FW-1:0]     o_ans,
    output logic [SW-1:0]     o_side
);

    localparam int LS = DATA_W - 1;

    logic              r_v    [DATA_W];
    logic [DATA_W-1:0] r_num  [DATA_W];
    logic [FW-1:0]     r_rem  [DATA_W];
    logic [FW-1:0]     r_p    [DATA_W];
    logic [FW-1:0]     r_ans  [DATA_W];
    logic [SW-1:0]     r_side [DATA_W];

    logic              r_lv, r_lsmall;
    logic [DATA_W-1:0] r_lq;
    logic [FW-1:0]     r_lr, r_lp, r_lans;
    logic [SW-1:0]     r_lside;
    logic [3*GW-1:0]   g_rdata;

    logic [FW-1:0]        d, m, s;
    logic [DATA_W+FW-1:0] bm;
    logic [2*FW-1:0]      am;

    logic              r_ov;
    logic [DATA_W-1:0] r_ob;
    logic [FW-1:0]     r_oans;
    logic [SW-1:0]     r_oside;

    for (genvar k = 0; k < DATA_W; k++) begin : g_div
        logic              v_in;
        logic [DATA_W-1:0] num_in;
        logic [FW-1:0]     rem_in, p_in, ans_in;
        logic [SW-1:0]     side_in;
        logic [FW:0]       t, tsub;
        logic              ge;

        if (k == 0) begin : g_first
            assign v_in    = i_valid;
            assign num_in  = i_b;
            assign rem_in  = '0;
            assign p_in    = i_p;
            assign ans_in  = i_ans;
            assign side_in = i_side;
        end else begin : g_next
            assign v_in    = r_v[k-1];
            assign num_in  = r_num[k-1];
            assign rem_in  = r_rem[k-1];
            assign p_in    = r_p[k-1];
            assign ans_in  = r_ans[k-1];
            assign side_in = r_side[k-1];
        end

        assign t    = {rem_in, num_in[DATA_W-1]};
        assign tsub = t - {1'b0, p_in};
        assign ge   = (t >= {1'b0, p_in});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else begin
                r_v[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            r_num[k]  <= {num_in[DATA_W-2:0], ge};
            r_rem[k]  <= ge ? tsub[FW-1:0] : t[FW-1:0];
            r_p[k]    <= p_in;
            r_ans[k]  <= ans_in;
            r_side[k] <= side_in;
        end
    end

    tgq_ram #(.WIDTH(3 * GW), .DEPTH(1 << (2 * GW))) u_gcd (
        .i_clk   (i_clk),
        .i_we    (i_gcd_we),
        .i_waddr (i_gcd_waddr),
        .i_wdata (i_gcd_wdata),
        .i_raddr ({r_p[LS][GW-1:0], r_rem[LS][GW-1:0]}),
        .o_rdata (g_rdata)
    );

    always_ff @(posedge i_clk) begin
        r_lq     <= r_num[LS];
        r_lr     <= r_rem[LS];
        r_lp     <= r_p[LS];
        r_lans   <= r_ans[LS];
        r_lside  <= r_side[LS];
        r_lsmall <= (r_p[LS] <= FW'(ROOT_N));
    end

    always_comb begin
        if (r_lsmall) begin
            d = FW'(g_rdata[3*GW-1:2*GW]);
            m = FW'(g_rdata[2*GW-1:GW]);
            s = FW'(g_rdata[GW-1:0]);
        end else if (r_lr == '0) begin
            d = r_lp;
            m = FW'(1);
            s = '0;
        end else begin
            d = FW'(1);
            m = r_lp;
            s = r_lr;
        end
    end

    assign bm = {{FW{1'b0}}, r_lq} * {{DATA_W{1'b0}}, m};
    assign am = {{FW{1'b0}}, r_lans} * {{FW{1'b0}}, d};

    always_ff @(posedge i_clk) begin
        r_ob    <= bm[DATA_W-1:0] + {{(DATA_W - FW){1'b0}}, s};
        r_oans  <= am[FW-1:0];
        r_oside <= r_lside;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lv <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            r_lv <= r_v[LS];
            r_ov <= r_lv;
        end
    end

    assign o_valid = r_ov;
    assign o_b     = r_ob;
    assign o_ans   = r_oans;
    assign o_side  = r_oside;

endmodule

// ===== design/table_gcd_query_top.sv =====
// table-driven gcd of two 31-bit operands
// a query beat is taken at a rising edge with start high and busy low; it
// carries both operands in i_query, order does not matter
// each result is shown on o_result for exactly one cycle with o_done high;
// the receiver takes it in that cycle and cannot hold it off
// each query passes the input register, the factor steps and the result
// register in order; a new query can be taken every cycle, so results
// leave in order at one per cycle
// each factor step runs a 31-stage bit-per-stage divider, one read of its
// own copy of the small gcd table and one multiply-add
// after reset busy stays high while the tables are built: a clearing sweep
// over all MAX_N+1 entries, a sieve of least prime factors, a factor pass,
// and in parallel a gcd table pass over all (ROOT_N+1)^2 operand pairs;
// the longer path sets when busy falls
// a smaller operand above MAX_N gives 0 with out_of_range set
module table_gcd_query_top import tgq_pkg::*; #(
    parameter int MAX_N = 4095,
    parameter int ROOT_N = 63
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    input  t_query  i_query,
    output logic    o_done,
    output t_result o_result
);

    localparam int FW = $clog2(MAX_N + 1);
    localparam int GW = $clog2(ROOT_N + 1);
    localparam int SW = 2 * FW + 2;

    logic            ready;
    logic            fac_we;
    logic [FW-1:0]   fac_waddr, fac_raddr, b_raddr;
    logic [3*FW-1:0] fac_wdata, fac_rdata;
    logic            gcd_we;
    logic [2*GW-1:0] gcd_waddr;
    logic [3*GW-1:0] gcd_wdata;

    logic              accept;
    logic [DATA_W-1:0] a_min, a_max;

    logic              r_av, r_aoor, r_azero;
    logic [DATA_W-1:0] r_ab;

    logic              s0_v, s1_v, s2_v;
    logic [DATA_W-1:0] s0_b, s1_b, s2_b;
    logic [FW-1:0]     s0_ans, s1_ans, s2_ans;
    logic [SW-1:0]     side_in, s0_side, s1_side, s2_side;

    logic    r_done;
    t_result r_result;

    tgq_build #(.MAX_N(MAX_N), .ROOT_N(ROOT_N)) u_build (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .o_ready     (ready),
        .o_fac_we    (fac_we),
        .o_fac_waddr (fac_waddr),
        .o_fac_wdata (fac_wdata),
        .o_fac_raddr (b_raddr),
        .i_fac_rdata (fac_rdata),
        .o_gcd_we    (gcd_we),
        .o_gcd_waddr (gcd_waddr),
        .o_gcd_wdata (gcd_wdata)
    );

    assign busy   = !ready;
    assign accept = start && ready;
    assign a_min  = (i_query.first_value > i_query.second_value) ?
                    i_query.second_value : i_query.first_value;
    assign a_max  = (i_query.first_value > i_query.second_value) ?
                    i_query.first_value : i_query.second_value;

    assign fac_raddr = ready ? a_min[FW-1:0] : b_raddr;

    tgq_ram #(.WIDTH(3 * FW), .DEPTH(MAX_N + 1)) u_factor (
        .i_clk   (i_clk),
        .i_we    (fac_we),
        .i_waddr (fac_waddr),
        .i_wdata (fac_wdata),
        .i_raddr (fac_raddr),
        .o_rdata (fac_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_av   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_av   <= accept;
            r_done <= s2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ab    <= a_max;
        r_aoor  <= (a_min > DATA_W'(MAX_N));
        r_azero <= (a_min == '0);
    end

    // side word: third factor, second factor, range flag, zero flag
    assign side_in = {fac_rdata[3*FW-1:FW], r_aoor, r_azero};

    tgq_step #(.MAX_N(MAX_N), .ROOT_N(ROOT_N), .SW(SW)) u_step0 (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_gcd_we    (gcd_we),
        .i_gcd_waddr (gcd_waddr),
        .i_gcd_wdata (gcd_wdata),
        .i_valid     (r_av),
        .i_b         (r_ab),
        .i_p         (fac_rdata[FW-1:0]),
        .i_ans       (FW'(1)),
        .i_side      (side_in),
        .o_valid     (s0_v),
        .o_b         (s0_b),
        .o_ans       (s0_ans),
        .o_side      (s0_side)
    );

    tgq_step #(.MAX_N(MAX_N), .ROOT_N(ROOT_N), .SW(SW)) u_step1 (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_gcd_we    (gcd_we),
        .i_gcd_waddr (gcd_waddr),
        .i_gcd_wdata (gcd_wdata),
        .i_valid     (s0_v),
        .i_b         (s0_b),
        .i_p         (s0_side[FW+1:2]),
        .i_ans       (s0_ans),
        .i_side      (s0_side),
        .o_valid     (s1_v),
        .o_b         (s1_b),
        .o_ans       (s1_ans),
        .o_side      (s1_side)
    );

    tgq_step #(.MAX_N(MAX_N), .ROOT_N(ROOT_N), .SW(SW)) u_step2 (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_gcd_we    (gcd_we),
        .i_gcd_waddr (gcd_waddr),
        .i_gcd_wdata (gcd_wdata),
        .i_valid     (s1_v),
        .i_b         (s1_b),
        .i_p         (s1_side[2*FW+1:FW+2]),
        .i_ans       (s1_ans),
        .i_side      (s1_side),
        .o_valid     (s2_v),
        .o_b         (s2_b),
        .o_ans       (s2_ans),
        .o_side      (s2_side)
    );

    always_ff @(posedge i_clk) begin
        r_result.out_of_range <= s2_side[1];
        if (s2_side[1]) begin
            r_result.gcd_value <= '0;
        end else if (s2_side[0]) begin
            r_result.gcd_value <= s2_b;
        end else begin
            r_result.gcd_value <= {{(DATA_W - FW){1'b0}}, s2_ans};
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule
